### rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned KEY_BITS        = 32;
  localparam int unsigned VALUE_BITS      = 32;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Word index of each configuration register (byte address bit 2).
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;
  } lkvc_req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } lkvc_rsp_t;

endpackage

### rtl/core/lkvc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
//
// Requests enter on in_valid_i/in_stall_o with in_data_i; every request gives
// exactly one response on out_valid_o/out_stall_i with out_data_o. A transfer
// happens at a clock edge where valid is high and stall is low.
// Keys, values and recency ranks live in one RAM with a registered read. Each
// request first sweeps all ENTRIES words to find the key, the least recent
// entry and the first free entry, then decides, then sweeps again to age the
// other entries and write the chosen one. A put or a get hit uses both sweeps;
// a get miss skips the second sweep.
// The response sits in an output register; a stalled receiver holds only the
// final step, and a new request is taken meanwhile. One request is in work at
// a time.
// Capacity is written over the APB port (register 0, byte address 0); the user
// must write it only while the cache is idle; the block does not enforce it.
// Reset empties the cache and sets capacity to 16; valid flip-flops spare the RAM a clear.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lkvc_pkg::lkvc_req_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lkvc_pkg::lkvc_rsp_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  import lkvc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES);

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [RANK_W-1:0]     rank;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   prv_q;
  lkvc_req_t          req_q;
  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   occ_q;
  logic [CAP_W-1:0]   cap_q;

  logic                  found_q, any_q, free_q;
  logic [IDX_W-1:0]      fidx_q, bidx_q, free_idx_q;
  logic [RANK_W-1:0]     frank_q, brank_q;
  logic [VALUE_BITS-1:0] fvalue_q;
  logic [KEY_BITS-1:0]   bkey_q;

  logic [IDX_W-1:0]  tgt_q;
  logic [RANK_W-1:0] old_q;
  logic              was_valid_q;
  lkvc_rsp_t         res_q;
  lkvc_rsp_t         res_d;
  logic              out_valid_q;
  lkvc_rsp_t         out_q;

  logic             in_fire;
  logic             cap_wr;
  logic             sweeping;
  logic             proc;
  logic             rd_valid;
  logic             is_put;
  logic             room;
  logic [CMP_W-1:0] cap_ext, eff_cap;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

  // Capacity zero acts as one; anything above the array size saturates.
  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign room   = CMP_W'(occ_q) < eff_cap;
  assign is_put = (req_q.req_type == REQ_PUT);

  always_comb begin
    res_d = '0;
    if (found_q) begin
      res_d.hit        = 1'b1;
      res_d.read_value = is_put ? '0 : fvalue_q;
    end else if (is_put && !room) begin
      res_d.evicted     = 1'b1;
      res_d.evicted_key = bkey_q;
    end
  end

  // Both sweeps issue address cnt_q and see the data of address prv_q in the
  // following cycle, so the write-back address always trails the read address.
  assign sweeping  = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
  assign ram_re    = sweeping && (cnt_q != CNT_LAST);
  assign ram_raddr = cnt_q[IDX_W-1:0];
  assign proc      = sweeping && (cnt_q != '0);
  assign rd_valid  = valid_q[prv_q];
  assign ram_waddr = prv_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    if ((state_q == ST_UPDATE) && proc) begin
      priority if (prv_q == tgt_q) begin
        ram_we          = 1'b1;
        ram_wdata.key   = req_q.lookup_key;
        ram_wdata.value = is_put ? req_q.write_value : ram_rdata.value;
        ram_wdata.rank  = '0;
      end else if (rd_valid && (!was_valid_q || (ram_rdata.rank < old_q))) begin
        ram_we         = 1'b1;
        ram_wdata.rank = ram_rdata.rank + 1'b1;
      end else begin
        ram_we = 1'b0;
      end
    end
  end

  lkvc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prv_q       <= '0;
      req_q       <= '0;
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= CAP_RESET;
      found_q     <= 1'b0;
      any_q       <= 1'b0;
      free_q      <= 1'b0;
      fidx_q      <= '0;
      bidx_q      <= '0;
      free_idx_q  <= '0;
      frank_q     <= '0;
      brank_q     <= '0;
      fvalue_q    <= '0;
      bkey_q      <= '0;
      tgt_q       <= '0;
      old_q       <= '0;
      was_valid_q <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cap_wr) begin
        cap_q <= pwdata[CAP_W-1:0];
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      if (sweeping) begin
        if (cnt_q != CNT_LAST) begin
          cnt_q <= cnt_q + 1'b1;
        end
        prv_q <= cnt_q[IDX_W-1:0];
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            req_q   <= in_data_i;
            cnt_q   <= '0;
            found_q <= 1'b0;
            any_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (proc) begin
            if (rd_valid) begin
              if (!found_q && (ram_rdata.key == req_q.lookup_key)) begin
                found_q  <= 1'b1;
                fidx_q   <= prv_q;
                frank_q  <= ram_rdata.rank;
                fvalue_q <= ram_rdata.value;
              end
              if (!any_q || (ram_rdata.rank > brank_q)) begin
                any_q   <= 1'b1;
                bidx_q  <= prv_q;
                brank_q <= ram_rdata.rank;
                bkey_q  <= ram_rdata.key;
              end
            end else if (!free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= prv_q;
            end
          end
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt_q <= '0;
          res_q <= res_d;
          priority if (found_q) begin
            tgt_q       <= fidx_q;
            old_q       <= frank_q;
            was_valid_q <= 1'b1;
            state_q     <= ST_UPDATE;
          end else if (is_put && room) begin
            // Room left: fill the lowest free entry, every valid entry ages.
            tgt_q               <= free_idx_q;
            was_valid_q         <= 1'b0;
            valid_q[free_idx_q] <= 1'b1;
            occ_q               <= occ_q + 1'b1;
            state_q             <= ST_UPDATE;
          end else if (is_put) begin
            tgt_q       <= bidx_q;
            old_q       <= brank_q;
            was_valid_q <= 1'b1;
            state_q     <= ST_UPDATE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_UPDATE: begin
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == CNT_W'($countones(valid_q)))
    else $error("occupancy count disagrees with valid bits");

  a_no_ram_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("write-back collides with the read of the same entry");

  a_hit_excludes_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.evicted))
    else $error("response reports both a hit and an eviction");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i))
      |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished request was not loaded into the output register");

endmodule

### tb/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key/value cache with an APB capacity register.
module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam int unsigned ENTRIES       = ENTRIES_DEFAULT;
  localparam int unsigned SETTLE_CYCLES = 2 * ENTRIES + 8;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned POOL_SIZE     = ENTRIES + 5;
  localparam int unsigned PHASE_ITEMS   = 125;

  // Tracks the cache contents and recency order, and holds the responses still owed.
  class cache_scoreboard;
    bit                    entry_used[ENTRIES];
    logic [KEY_BITS-1:0]   entry_key[ENTRIES];
    logic [VALUE_BITS-1:0] entry_value[ENTRIES];
    int unsigned           entry_age[ENTRIES];
    int unsigned           used_count;
    logic [CAP_W-1:0]      capacity;
    lkvc_rsp_t             pending_responses[$];
    int unsigned           errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        entry_used[i]  = 1'b0;
        entry_key[i]   = '0;
        entry_value[i] = '0;
        entry_age[i]   = 0;
      end
      used_count = 0;
      capacity   = CAP_RESET;
      errors     = 0;
    endfunction

    // An entry that was not in use counts as older than every other entry.
    function void make_recent(int idx, bit was_used);
      int unsigned old_age;
      old_age = entry_age[idx];
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != idx && entry_used[i] && (!was_used || entry_age[i] < old_age)) begin
          entry_age[i]++;
        end
      end
      entry_age[idx] = 0;
    endfunction

    function void apply_request(lkvc_req_t req);
      lkvc_rsp_t   rsp;
      int          found;
      int          slot;
      int unsigned cap_eff;
      rsp   = '0;
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (entry_used[i] && entry_key[i] == req.lookup_key) begin
          found = i;
          break;
        end
      end
      if (found >= 0) begin
        rsp.hit = 1'b1;
        make_recent(found, 1'b1);
        if (req.req_type == REQ_PUT) begin
          entry_value[found] = req.write_value;
        end else begin
          rsp.read_value = entry_value[found];
        end
      end else if (req.req_type == REQ_PUT) begin
        cap_eff = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
        slot = -1;
        if (used_count < cap_eff) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!entry_used[i]) begin
              slot = i;
              break;
            end
          end
        end
        if (slot >= 0) begin
          make_recent(slot, 1'b0);
          entry_used[slot] = 1'b1;
          used_count++;
        end else begin
          // Capacity is at least one, so a full cache always has a valid entry to evict.
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_used[i] && (slot < 0 || entry_age[i] > entry_age[slot])) begin
              slot = i;
            end
          end
          rsp.evicted     = 1'b1;
          rsp.evicted_key = entry_key[slot];
          make_recent(slot, 1'b1);
        end
        entry_key[slot]   = req.lookup_key;
        entry_value[slot] = req.write_value;
      end
      pending_responses.push_back(rsp);
    endfunction

    function void check_response(lkvc_rsp_t got);
      lkvc_rsp_t exp_rsp;
      if (pending_responses.size() == 0) begin
        $error("response transfer with no request outstanding: %p", got);
        errors++;
        return;
      end
      exp_rsp = pending_responses.pop_front();
      if (got.hit !== exp_rsp.hit) begin
        $error("hit: expected %0d, actual %0d", exp_rsp.hit, got.hit);
        errors++;
      end
      if (got.read_value !== exp_rsp.read_value) begin
        $error("read_value: expected %h, actual %h", exp_rsp.read_value, got.read_value);
        errors++;
      end
      if (got.evicted !== exp_rsp.evicted) begin
        $error("evicted: expected %0d, actual %0d", exp_rsp.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== exp_rsp.evicted_key) begin
        $error("evicted_key: expected %h, actual %h", exp_rsp.evicted_key, got.evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  lkvc_req_t             in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  lkvc_rsp_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cache_scoreboard     sb;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         tb_errors = 0;
  int unsigned         quiet_cycles = 0;
  logic [KEY_BITS-1:0] key_pool[POOL_SIZE];

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.apply_request(in_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_response(out_data_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic kind, input logic [KEY_BITS-1:0] key,
                              input logic [VALUE_BITS-1:0] value);
    lkvc_req_t req;
    req.req_type    = kind;
    req.lookup_key  = key;
    req.write_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Always waits for the clock before returning, so valid never drops and rises in one step.
  task automatic wait_for_responses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_responses.size() != 0);
  endtask

  task automatic apb_access(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [APB_DATA_W-1:0] readback;
    wait_for_responses();
    // Leave the cache idle for a while before the register changes.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_access(1'b1, {REG_CAPACITY, 2'b00}, APB_DATA_W'(cap), readback);
    apb_access(1'b0, {REG_CAPACITY, 2'b00}, '0, readback);
    if (readback[CAP_W-1:0] !== cap) begin
      $error("capacity: expected %0d, actual %0d", cap, readback[CAP_W-1:0]);
      tb_errors++;
    end
    sb.capacity = cap;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned sender_idle,
                           input int unsigned receiver_idle);
    int unsigned         span;
    int unsigned         pick;
    logic [KEY_BITS-1:0] key;
    set_capacity(cap);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    span = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // Keys mostly come from a working set a little larger than the capacity,
      // which keeps both hits and evictions frequent.
      pick = $urandom_range(99);
      if (pick < 80) begin
        key = key_pool[$urandom_range(span + 3)];
      end else if (pick < 90) begin
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        key = $urandom();
      end
      if ($urandom_range(99) == 0) begin
        wait_for_responses();
      end
      send_request(1'($urandom_range(1)), key, $urandom());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_cap[10];
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom();
    end
    phase_cap = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16, 5'd0, 5'd3};
    phase_cap[8] = $urandom_range(31);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two entries: fill, hit, put over a present key, and evict the least recent.
    set_capacity(5'd2);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_PUT, 32'h0000_0005, 32'h1234_5678);
    send_request(REQ_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0005, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0007, 32'h5A5A_5A5A);
    // Capacity zero acts as one and lies below the occupancy: new keys evict.
    set_capacity(5'd0);
    send_request(REQ_PUT, 32'h0000_0009, 32'h0000_0001);
    send_request(REQ_GET, 32'h0000_0007, 32'h0000_0000);
    send_request(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Capacity above the entry count saturates, so free entries fill again.
    set_capacity(5'd31);
    send_request(REQ_PUT, 32'h0000_0001, 32'h0000_0001);
    send_request(REQ_PUT, 32'h0000_0002, 32'h0000_0002);
    send_request(REQ_GET, 32'h0000_0007, 32'h0000_0000);
    send_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);

    for (int p = 0; p < 10; p++) begin
      if (p < 4) begin
        run_phase(phase_cap[p], 31, 67);
      end else if (p < 7) begin
        run_phase(phase_cap[p], 67, 31);
      end else begin
        run_phase(phase_cap[p], 0, 0);
      end
    end

    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && tb_errors == 0 && sb.pending_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
